### hw/rtl/afsc_pkg.sv
// Shared types and constants for the ADTS frame sync scanner.
package afsc_pkg;

  localparam int unsigned WIN_BYTES = 6;   // header window depth in bytes
  localparam int unsigned CNT_W     = 3;   // holds 0..WIN_BYTES
  localparam int unsigned LEN_W     = 13;  // ADTS frame length field
  localparam int unsigned SCAN_W    = 16;

  localparam logic [7:0]        SYNC_BYTE      = 8'hFF;
  localparam logic [3:0]        SYNC_NIBBLE    = 4'hF;
  localparam logic [1:0]        LAYER_ZERO     = 2'b00;
  localparam logic [SCAN_W-1:0] SCAN_LIMIT_RST = 16'd32768;

  typedef enum logic [1:0] {
    ST_HUNT,  // fill window and test positions
    ST_EMIT,  // drain header bytes out of the window
    ST_PASS   // pass frame body bytes straight through
  } state_t;

  // per-cell control: load the incoming byte, or take the right neighbor's tap
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

### hw/rtl/afsc_cell.sv
// One byte cell of the header window shift chain.
module afsc_cell
  import afsc_pkg::*;
(
  input  logic       clk,
  input  cell_ctl_t  ctl_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] nbr_i,
  output logic [7:0] tap_o
);

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  // tap shows the byte as it stands once this cycle's load is applied
  assign tap_o = ctl_i.load ? byte_i : data_r;

  always_comb begin
    if (ctl_i.shift) begin
      data_nxt = nbr_i;
    end else begin
      data_nxt = tap_o;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

### hw/rtl/adts_frame_sync_scanner.sv
// Top level of the ADTS frame sync scanner: window cell chain, control and output register.
//
//  channel | ports                                   | direction | handshake
//  --------+-----------------------------------------+-----------+----------------------
//  in      | in_byte_in                              | input     | in_valid / in_ready
//  out     | out_byte_out, out_frame_first,          | output    | out_valid / out_ready
//          | out_frame_last, out_frame_length,       |           |
//          | out_no_sync                             |           |
//  cfg     | cfg_scan_limit                          | input     | cfg_valid / cfg_ready
//
// While hunting or passing a frame body the block takes one byte per cycle. When a
// header is found, the window cells shift out min(length, 6) header bytes, one per
// cycle while the output register can take them; input is held while they drain.
// The single output register sets the pace under backpressure: input is taken only
// when that register is free or being drained. Reset (rst_n low, synchronous)
// empties the window, returns to hunting, clears the scan count and loads the scan
// limit with 32768.
module adts_frame_sync_scanner
  import afsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // input byte stream
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_byte_in,
  // result stream
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte_out,
  output logic             out_frame_first,
  output logic             out_frame_last,
  output logic [LEN_W-1:0] out_frame_length,
  output logic             out_no_sync,
  // configuration
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [SCAN_W-1:0] cfg_scan_limit
);

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;      // bytes held in the window
  logic [CNT_W-1:0]   emit_k_r, emit_k_nxt;    // header byte being emitted
  logic [LEN_W-1:0]   len_held_r, len_held_nxt;
  logic [LEN_W-1:0]   rem_r, rem_nxt;          // body bytes still to pass
  logic [SCAN_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic [SCAN_W-1:0]  scan_limit_r;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r;
  logic               out_first_r;
  logic               out_last_r;
  logic [LEN_W-1:0]   out_len_r;
  logic               out_ns_r;

  // result produced this cycle
  logic               res_vld;
  logic [7:0]         res_byte;
  logic               res_first;
  logic               res_last;
  logic [LEN_W-1:0]   res_len;
  logic               res_ns;

  // window chain
  cell_ctl_t [WIN_BYTES-1:0]       ctl;
  logic      [WIN_BYTES-1:0][7:0]  tap;

  logic               adv;
  logic               in_acc;
  logic               win_full;
  logic               scan_hit;
  logic [LEN_W-1:0]   hdr_len;
  logic               hdr_ok;
  logic [CNT_W-1:0]   emit_n;
  logic               emit_done;
  logic               long_frame;
  logic               pass_last;

  // ---------------------------------------------------------------------------
  // Window cell chain: cell 0 is the oldest byte; a shift drops it.
  // ---------------------------------------------------------------------------
  for (genvar gi = 0; gi < WIN_BYTES; gi++) begin : g_cell
    logic [7:0] nbr;
    if (gi == WIN_BYTES - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = tap[gi+1];
    end
    afsc_cell u_cell (
      .clk    (clk),
      .ctl_i  (ctl[gi]),
      .byte_i (in_byte_in),
      .nbr_i  (nbr),
      .tap_o  (tap[gi])
    );
  end

  // ---------------------------------------------------------------------------
  // Handshake and decode
  // ---------------------------------------------------------------------------
  // output slot is free next cycle when empty or being taken now
  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv && (state_r != ST_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // the incoming byte completes the window when five are already held
  assign win_full = (count_r == CNT_W'(WIN_BYTES - 1));
  assign scan_hit = (scan_cnt_r >= scan_limit_r);

  // header test on the window as it stands with the new byte in place
  always_comb begin
    if ((tap[0] == SYNC_BYTE) && (tap[1][7:4] == SYNC_NIBBLE) &&
        (tap[1][2:1] == LAYER_ZERO)) begin
      hdr_len = {tap[3][1:0], tap[4], tap[5][7:5]};
    end else begin
      hdr_len = '0;
    end
  end
  assign hdr_ok = (hdr_len != '0);

  // header bytes to emit: the frame length, capped at the window depth
  assign emit_n     = (len_held_r < LEN_W'(WIN_BYTES)) ? len_held_r[CNT_W-1:0]
                                                       : CNT_W'(WIN_BYTES);
  assign emit_done  = ((emit_k_r + CNT_W'(1)) == emit_n);
  assign long_frame = (len_held_r > LEN_W'(WIN_BYTES));
  assign pass_last  = (rem_r <= LEN_W'(1));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_HUNT: begin
        if (in_acc && win_full && !scan_hit && hdr_ok) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (adv && emit_done) begin
          state_nxt = long_frame ? ST_PASS : ST_HUNT;
        end
      end
      ST_PASS: begin
        if (in_acc && pass_last) begin
          state_nxt = ST_HUNT;
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath control and results
  // ---------------------------------------------------------------------------
  always_comb begin
    ctl          = '0;
    count_nxt    = count_r;
    emit_k_nxt   = emit_k_r;
    len_held_nxt = len_held_r;
    rem_nxt      = rem_r;
    scan_cnt_nxt = scan_cnt_r;
    res_vld      = 1'b0;
    res_byte     = '0;
    res_first    = 1'b0;
    res_last     = 1'b0;
    res_len      = '0;
    res_ns       = 1'b0;
    case (state_r)
      ST_HUNT: begin
        if (in_acc) begin
          // append the byte behind the last one held
          for (int i = 0; i < WIN_BYTES; i++) begin
            ctl[i].load = (count_r == CNT_W'(i));
          end
          if (!win_full) begin
            count_nxt = count_r + CNT_W'(1);
          end else if (scan_hit) begin
            // scan limit spent: report, drop the oldest byte, skip the test
            for (int i = 0; i < WIN_BYTES; i++) begin
              ctl[i].shift = 1'b1;
            end
            count_nxt    = CNT_W'(WIN_BYTES - 1);
            scan_cnt_nxt = '0;
            res_vld      = 1'b1;
            res_ns       = 1'b1;
          end else if (!hdr_ok) begin
            // no header here: advance one position
            for (int i = 0; i < WIN_BYTES; i++) begin
              ctl[i].shift = 1'b1;
            end
            count_nxt    = CNT_W'(WIN_BYTES - 1);
            scan_cnt_nxt = scan_cnt_r + SCAN_W'(1);
          end else begin
            // sync: hold the full window for draining
            count_nxt    = CNT_W'(WIN_BYTES);
            scan_cnt_nxt = '0;
            len_held_nxt = hdr_len;
            emit_k_nxt   = '0;
          end
        end
      end
      ST_EMIT: begin
        if (adv) begin
          for (int i = 0; i < WIN_BYTES; i++) begin
            ctl[i].shift = 1'b1;
          end
          res_vld    = 1'b1;
          res_byte   = tap[0];
          res_first  = (emit_k_r == '0);
          res_last   = ((LEN_W'(emit_k_r) + LEN_W'(1)) == len_held_r);
          res_len    = len_held_r;
          emit_k_nxt = emit_k_r + CNT_W'(1);
          count_nxt  = count_r - CNT_W'(1);
          if (emit_done && long_frame) begin
            rem_nxt = len_held_r - LEN_W'(WIN_BYTES);
          end
        end
      end
      ST_PASS: begin
        if (in_acc) begin
          res_vld  = 1'b1;
          res_byte = in_byte_in;
          res_last = pass_last;
          res_len  = len_held_r;
          rem_nxt  = pass_last ? '0 : (rem_r - LEN_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = adv ? res_vld : out_valid_r;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_HUNT;
      count_r      <= '0;
      emit_k_r     <= '0;
      len_held_r   <= '0;
      rem_r        <= '0;
      scan_cnt_r   <= '0;
      scan_limit_r <= SCAN_LIMIT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      emit_k_r    <= emit_k_nxt;
      len_held_r  <= len_held_nxt;
      rem_r       <= rem_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        scan_limit_r <= cfg_scan_limit;
      end
    end
  end

  // payload of the output register: load only when a result moves in
  always_ff @(posedge clk) begin
    if (adv && res_vld) begin
      out_byte_r  <= res_byte;
      out_first_r <= res_first;
      out_last_r  <= res_last;
      out_len_r   <= res_len;
      out_ns_r    <= res_ns;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_out     = out_byte_r;
  assign out_frame_first  = out_first_r;
  assign out_frame_last   = out_last_r;
  assign out_frame_length = out_len_r;
  assign out_no_sync      = out_ns_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(WIN_BYTES))
    else $error("window count beyond window depth");

  a_emit_blocks_in : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !in_ready)
    else $error("input taken while header bytes drain");

  a_emit_k_range : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (emit_k_r < emit_n))
    else $error("header emit index past header length");

  a_pass_rem : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PASS) |-> (rem_r != '0))
    else $error("passing a frame with nothing remaining");

  a_first_byte : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && emit_k_r == '0 && adv) |=>
      (out_valid && out_frame_first && !out_no_sync))
    else $error("first header byte not marked as frame start");

endmodule
